/* hw/rtl/drm_pkg.sv */
// Package: DES tables, command types and helper functions for the retail MAC core.
`default_nettype none
package drm_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned BlkW = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_CHAIN,
    CMD_FINAL,
    CMD_FINAL_NOCHAIN
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t         code;
    logic [BlkW-1:0]   block;
  } cmd_t;

  typedef logic [7:0] tbl64_t [64];
  typedef logic [7:0] tbl48_t [48];
  typedef logic [7:0] tbl56_t [56];
  typedef logic [7:0] tbl32_t [32];

  localparam tbl64_t T_IP = '{
    8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
    8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
    8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};
  localparam tbl64_t T_FP = '{
    8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
    8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
    8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
    8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};
  localparam tbl48_t T_E = '{
    8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd8,8'd9,8'd10,8'd11,
    8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,
    8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,
    8'd30,8'd31,8'd32,8'd1};
  localparam tbl32_t T_P = '{
    8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
    8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};
  localparam tbl56_t T_PC1 = '{
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
    8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
    8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
    8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};
  localparam tbl48_t T_PC2 = '{
    8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,8'd23,8'd19,8'd12,8'd4,
    8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,
    8'd51,8'd45,8'd33,8'd48,8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

  typedef logic [3:0] sbox_t [8][64];
  localparam sbox_t T_S = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(T_IP[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(T_FP[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64 - int'(T_PC1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56 - int'(T_PC2[i])];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sub);
    logic [47:0] x;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0]  b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(T_E[i])];
    x = x ^ sub;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      o[31-4*i -: 4] = T_S[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32 - int'(T_P[i])];
    return p;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/drm_stream_if.sv */
// Interface: valid/ready stream channel with a generic payload.
`default_nettype none
interface drm_stream_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/drm_front.sv */
// Front end: pack bytes into blocks and issue chain and finish commands.
`default_nettype none
module drm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pad_enable,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output drm_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import drm_pkg::*;

  logic [63:0] block_buffer;
  logic [2:0]  byte_position;
  logic        pend_valid;
  cmd_t        pend;
  logic [63:0] merged;
  logic        take;
  logic        out_free;

  // A second command is pending when a full block also ends a padded message.
  assign out_free = !cmd_valid || cmd_ready;
  assign in_ready = !pend_valid && out_free;
  assign take = in_valid && in_ready;

  always_comb begin
    merged = block_buffer;
    merged[63 - 8*byte_position -: 8] = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_buffer <= '0;
      byte_position <= '0;
      pend_valid <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (out_free) begin
        cmd_valid <= 1'b0;
        if (pend_valid) begin
          cmd <= pend;
          cmd_valid <= 1'b1;
          pend_valid <= 1'b0;
        end
      end
      if (take) begin
        if (byte_position == 3'd7) begin
          cmd.block <= merged;
          cmd_valid <= 1'b1;
          block_buffer <= '0;
          byte_position <= '0;
          if (!last_byte) begin
            cmd.code <= CMD_CHAIN;
          end else if (pad_enable) begin
            cmd.code <= CMD_CHAIN;
            pend.code <= CMD_FINAL;
            pend.block <= {8'h80, 56'd0};
            pend_valid <= 1'b1;
          end else begin
            cmd.code <= CMD_FINAL;
          end
        end else if (last_byte) begin
          cmd_valid <= 1'b1;
          block_buffer <= '0;
          byte_position <= '0;
          if (pad_enable) begin
            cmd.code <= CMD_FINAL;
            cmd.block <= merged | ({8'h80, 56'd0} >> (8*(byte_position + 3'd1)));
          end else begin
            cmd.code <= CMD_FINAL_NOCHAIN;
            cmd.block <= '0;
          end
        end else begin
          block_buffer <= merged;
          byte_position <= byte_position + 3'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/drm_queue.sv */
// Queue: short command FIFO between front end and DES engine.
`default_nettype none
module drm_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  drm_pkg::cmd_t wr_cmd,
  input  wire logic     wr_valid,
  output logic          wr_ready,
  output drm_pkg::cmd_t rd_cmd,
  output logic          rd_valid,
  input  wire logic     rd_ready
);
  import drm_pkg::*;

  cmd_t       slots [QueueDepth];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = count != 2'(QueueDepth);
  assign rd_valid = count != 2'd0;
  assign rd_cmd = slots[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_cmd;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/drm_engine.sv */
// Back end: iterative DES round unit running the chain and the final 2-key step.
`default_nettype none
module drm_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [63:0]   key_first,
  input  wire logic [63:0]   key_second,
  input  drm_pkg::cmd_t      cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  output logic               mac_valid,
  input  wire logic          mac_ready,
  output logic [63:0]        mac
);
  import drm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;
  typedef enum logic [1:0] {P_CHAIN, P_DEC, P_ENC} phase_t;

  state_t      state;
  phase_t      phase;
  logic        fin;
  logic [3:0]  round;
  logic [31:0] l;
  logic [31:0] r;
  logic [27:0] c;
  logic [27:0] d;
  logic        dec;
  logic [63:0] chain_value;
  logic [63:0] result;
  logic [27:0] c_rot;
  logic [27:0] d_rot;
  logic [27:0] c_use;
  logic [27:0] d_use;
  logic [47:0] sub;
  logic [31:0] r_next;
  logic [63:0] des_out;
  logic        one_shift;
  logic        next_one;

  assign one_shift = round == 4'd0 || round == 4'd1 || round == 4'd8 || round == 4'd15;
  assign next_one = round == 4'd15 || round == 4'd0 || round == 4'd7 || round == 4'd14;

  // Encrypt rotates left before each round; decrypt uses the key as is, then rotates right.
  always_comb begin
    c_rot = one_shift ? {c[26:0], c[27]} : {c[25:0], c[27:26]};
    d_rot = one_shift ? {d[26:0], d[27]} : {d[25:0], d[27:26]};
    c_use = dec ? c : c_rot;
    d_use = dec ? d : d_rot;
    sub = perm_pc2({c_use, d_use});
    r_next = l ^ feistel(r, sub);
    des_out = perm_fp({r_next, r});
  end

  assign cmd_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    logic [55:0] cd;
    logic [63:0] ip;
    if (rst) begin
      state <= S_IDLE;
      mac_valid <= 1'b0;
      chain_value <= '0;
    end else begin
      if (mac_valid && mac_ready) mac_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            fin <= cmd.code != CMD_CHAIN;
            round <= '0;
            cd = perm_pc1(key_first);
            if (cmd.code == CMD_FINAL_NOCHAIN) begin
              cd = perm_pc1(key_second);
              ip = perm_ip(chain_value);
              phase <= P_DEC;
              dec <= 1'b1;
            end else begin
              ip = perm_ip(chain_value ^ cmd.block);
              phase <= P_CHAIN;
              dec <= 1'b0;
            end
            c <= cd[55:28];
            d <= cd[27:0];
            l <= ip[63:32];
            r <= ip[31:0];
            state <= S_RUN;
          end
        end
        S_RUN: begin
          l <= r;
          r <= r_next;
          if (dec) begin
            c <= round == 4'd15 ? c
                 : (next_one ? {c[0], c[27:1]} : {c[1:0], c[27:2]});
            d <= round == 4'd15 ? d
                 : (next_one ? {d[0], d[27:1]} : {d[1:0], d[27:2]});
          end else begin
            c <= c_rot;
            d <= d_rot;
          end
          round <= round + 4'd1;
          if (round == 4'd15) begin
            round <= '0;
            case (phase)
              P_CHAIN: begin
                if (fin) begin
                  cd = perm_pc1(key_second);
                  ip = perm_ip(des_out);
                  c <= cd[55:28];
                  d <= cd[27:0];
                  l <= ip[63:32];
                  r <= ip[31:0];
                  phase <= P_DEC;
                  dec <= 1'b1;
                end else begin
                  chain_value <= des_out;
                  state <= S_IDLE;
                end
              end
              P_DEC: begin
                cd = perm_pc1(key_first);
                ip = perm_ip(des_out);
                c <= cd[55:28];
                d <= cd[27:0];
                l <= ip[63:32];
                r <= ip[31:0];
                phase <= P_ENC;
                dec <= 1'b0;
              end
              default: begin
                result <= des_out;
                chain_value <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!mac_valid || mac_ready) begin
            mac <= result;
            mac_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/des_retail_mac_core.sv */
// Top level: ISO 9797-1 algorithm 3 retail MAC over a byte stream.
//
// Bytes enter on in_ch (data_byte, last_byte); one 64-bit MAC leaves on
// out_ch per message, after the beat that carries last_byte.
// The front end packs bytes into 8-byte blocks and queues chain or finish
// commands; the back end runs one DES round per cycle on a shared round
// unit. The front end keeps taking bytes while the engine works, until the
// queue is full. The MAC for a message follows the DES passes of its final
// command (a chain pass if it carries a block, a decrypt with key_second, an
// encrypt with key_first) and of any block queued ahead of it.
// Configuration writes (cfg_we, cfg_index, cfg_data) to a key take effect
// at the next DES pass that loads that key, and to pad_enable at the next
// last byte. After reset the keys are zero and padding is on.
// When out_ch stalls, the MAC is held and the engine keeps chaining blocks;
// it stops only when the next MAC is ready, then the queue and in_ch back up.
`default_nettype none
module des_retail_mac_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  drm_stream_if.sink       in_ch,
  drm_stream_if.source     out_ch
);
  import drm_pkg::*;

  localparam logic [1:0] RegKeyFirst = 2'd0;
  localparam logic [1:0] RegKeySecond = 2'd1;
  localparam logic [1:0] RegPadEnable = 2'd2;

  logic [63:0] key_first;
  logic [63:0] key_second;
  logic        pad_enable;
  cmd_t        f_cmd;
  logic        f_valid;
  logic        f_ready;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_first <= '0;
      key_second <= '0;
      pad_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyFirst: key_first <= cfg_data;
        RegKeySecond: key_second <= cfg_data;
        RegPadEnable: pad_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  drm_front u_front (
    .clk(clk), .rst(rst), .pad_enable(pad_enable),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .data_byte(in_ch.data[7:0]), .last_byte(in_ch.data[8]),
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  drm_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_cmd(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_cmd(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  drm_engine u_engine (
    .clk(clk), .rst(rst), .key_first(key_first), .key_second(key_second),
    .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .mac_valid(out_ch.valid), .mac_ready(out_ch.ready), .mac(out_ch.data)
  );
endmodule
`default_nettype wire

/* test/tb_mac_pkg.sv */
// Testbench package: register indexes of the retail MAC configuration port.
package tb_mac_pkg;
  typedef enum logic [1:0] {
    REG_KEY_FIRST  = 2'd0,
    REG_KEY_SECOND = 2'd1,
    REG_PAD_ENABLE = 2'd2,
    REG_UNUSED     = 2'd3
  } mac_reg_t;
endpackage

/* test/mac_checker.sv */
// Checker: predicts retail MACs from the observed byte and config beats and compares them.
module mac_checker
  import drm_pkg::*;
  import tb_mac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  drm_stream_if       in_ch,
  drm_stream_if       out_ch,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] key_a, key_b;
  logic        pad_on;
  logic [63:0] chain, held;
  int          fill;
  logic [63:0] mac_q[$];

  function automatic logic [63:0] des(input logic [63:0] key, input logic [63:0] blk,
                                      input bit inverse);
    logic [47:0] rk [16];
    logic [55:0] cd, cd2;
    logic [27:0] c, d;
    logic [63:0] ip, pre, res;
    logic [31:0] l, r, t, f, o;
    logic [47:0] x;
    logic [5:0]  b;
    int          sh;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(T_PC1[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int k = 0; k < 16; k++) begin
      sh = (k == 0 || k == 1 || k == 8 || k == 15) ? 1 : 2;
      c = (c << sh) | (c >> (28 - sh));
      d = (d << sh) | (d >> (28 - sh));
      cd2 = {c, d};
      for (int i = 0; i < 48; i++) rk[k][47-i] = cd2[56 - int'(T_PC2[i])];
    end
    for (int i = 0; i < 64; i++) ip[63-i] = blk[64 - int'(T_IP[i])];
    l = ip[63:32];
    r = ip[31:0];
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(T_E[i])];
      x = x ^ rk[inverse ? 15 - k : k];
      for (int i = 0; i < 8; i++) begin
        b = x[47-6*i -: 6];
        o[31-4*i -: 4] = T_S[i][{b[5], b[0]} * 16 + b[4:1]];
      end
      for (int i = 0; i < 32; i++) f[31-i] = o[32 - int'(T_P[i])];
      t = r;
      r = l ^ f;
      l = t;
    end
    pre = {r, l};
    for (int i = 0; i < 64; i++) res[63-i] = pre[64 - int'(T_FP[i])];
    return res;
  endfunction

  task automatic absorb_byte(input logic [7:0] data_byte, input logic last_byte);
    held |= 64'(data_byte) << (56 - 8 * fill);
    fill++;
    if (fill == 8) begin
      chain = des(key_a, chain ^ held, 1'b0);
      held = '0;
      fill = 0;
    end
    if (last_byte) begin
      if (pad_on) begin
        held |= 64'h80 << (56 - 8 * fill);
        chain = des(key_a, chain ^ held, 1'b0);
      end
      mac_q.push_back(des(key_a, des(key_b, chain, 1'b1), 1'b0));
      chain = '0;
      held = '0;
      fill = 0;
    end
  endtask

  assign pending = mac_q.size();

  always @(posedge clk) begin
    if (rst) begin
      key_a = '0;
      key_b = '0;
      pad_on = 1'b1;
      chain = '0;
      held = '0;
      fill = 0;
      mac_q.delete();
    end else begin
      if (cfg_we) begin
        case (mac_reg_t'(cfg_index))
          REG_KEY_FIRST:  key_a = cfg_data;
          REG_KEY_SECOND: key_b = cfg_data;
          REG_PAD_ENABLE: pad_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) absorb_byte(in_ch.data[7:0], in_ch.data[8]);
      if (out_ch.valid && out_ch.ready) begin
        if (mac_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected mac beat %h", out_ch.data);
        end else begin
          if (out_ch.data !== mac_q[0]) begin
            fails++;
            if (fails <= 10) $display("mac mismatch: expected %h actual %h", mac_q[0],
                                      out_ch.data);
          end
          void'(mac_q.pop_front());
        end
      end
    end
  end

  initial fails = 0;
endmodule

/* test/tb_top.sv */
// Testbench top: drives the retail MAC core with messages and config phases, reports verdict.
module tb_top;
  import tb_mac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fails, pending;
  bit          quiet, hold_now;
  int          bytes_sent;

  drm_stream_if #(9)  in_ch ();
  drm_stream_if #(64) out_ch ();

  des_retail_mac_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  mac_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #16000000;
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(input mac_reg_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
    int  gap;
    bit  hs;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {last_byte, data_byte};
    do begin
      @(negedge clk);
      hs = in_ch.ready;
      @(posedge clk);
    end while (!hs);
    bytes_sent++;
  endtask

  // fill: 0 random, 1 all zero, 2 all ones
  task automatic send_msg(input int len, input int fill);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      v = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
      send_byte(v, i == len - 1);
    end
  endtask

  initial begin
    bit hs;
    int n;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_now) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_now = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        hs = out_ch.valid;
        @(posedge clk);
      end while (!hs);
    end
  end

  initial begin
    int target;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_FIRST;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    quiet = 1'b0;
    hold_now = 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_msg(1, 1);
    send_msg(1, 2);
    send_msg(7, 0);
    send_msg(8, 2);
    send_msg(9, 0);
    drain();

    write_reg(REG_KEY_FIRST, '1);
    write_reg(REG_PAD_ENABLE, 64'd0);
    send_msg(1, 0);
    send_msg(7, 1);
    send_msg(8, 0);
    send_msg(9, 2);
    send_msg(16, 0);
    drain();

    write_reg(REG_KEY_FIRST, '0);
    write_reg(REG_KEY_SECOND, '1);
    write_reg(REG_PAD_ENABLE, 64'd1);
    write_reg(REG_UNUSED, '1);
    send_msg(16, 0);
    send_msg(3, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_KEY_FIRST, {$urandom, $urandom});
      write_reg(REG_KEY_SECOND, {$urandom, $urandom});
      write_reg(REG_PAD_ENABLE, 64'(ph % 3 != 1));
      quiet = (ph == 2);
      if (ph == 4) hold_now = 1'b1;
      target = bytes_sent + 280;
      while (bytes_sent < target)
        send_msg(($urandom_range(0, 15) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20), 0);
      quiet = 1'b0;
      drain();
    end

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/drm_pkg.sv
hw/rtl/drm_stream_if.sv
hw/rtl/drm_front.sv
hw/rtl/drm_queue.sv
hw/rtl/drm_engine.sv
hw/rtl/des_retail_mac_core.sv
test/tb_mac_pkg.sv
test/mac_checker.sv
test/tb_top.sv
